// File: rtl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Types and constants shared by the ready-queue scheduler modules.
// ----------------------------------------------------------------------------
package rqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QCNT_W      = 5;

    localparam logic FUNC_ARRIVAL  = 1'b0;
    localparam logic FUNC_COMPLETE = 1'b1;

    localparam logic POLICY_PRIORITY = 1'b0;
    localparam logic POLICY_SRTF     = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] proc_id;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  priority_req;
        logic [15:0] timestamp;
        logic [15:0] running_remaining;
    } t_req;

    typedef struct packed {
        logic              valid_res;
        logic [15:0]       out_pid;
        logic [15:0]       out_arrival;
        logic [15:0]       out_burst;
        logic [7:0]        out_priority;
        logic [15:0]       start_time;
        logic [16:0]       end_time;
        logic [15:0]       remaining;
        logic [QCNT_W-1:0] queue_count;
        logic              dropped;
    } t_res;

    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
        logic [7:0]  priority_lvl;
    } t_slot;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
        logic [IDX_W-1:0] rd_idx;
    } t_tbl_req;

    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] count;
    } t_tbl_stat;

endpackage

// File: rtl/preemptive_ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_ready_queue_scheduler
// Preemptive priority / shortest-remaining-time-first process scheduler.
// ----------------------------------------------------------------------------
// One event at a time. An arrival passes the arrive and finish states to
// the result register. A completion steps one compare unit over every table
// slot, one slot per clock through the table's read port, then drains,
// completes and finishes. The next event is taken once the result is in the
// output register, while that result still waits for its transfer.
// ----------------------------------------------------------------------------
module preemptive_ready_queue_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rqs_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rqs_pkg::t_res o_out_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    logic                r_policy;
    rqs_pkg::t_tbl_req   tbl_req;
    rqs_pkg::t_tbl_stat  tbl_stat;
    rqs_pkg::t_slot      wr_data;
    rqs_pkg::t_slot      rd_data;
    logic                rd_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= rqs_pkg::POLICY_PRIORITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    rqs_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld),
        .o_stat    (tbl_stat)
    );

    rqs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_policy    (r_policy),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .o_tbl_req   (tbl_req),
        .o_wr_data   (wr_data),
        .i_tbl_stat  (tbl_stat),
        .i_rd_data   (rd_data),
        .i_rd_vld    (rd_vld)
    );

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input transfer not followed by busy");

    a_null_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_res.valid_res) |->
        (o_out_res.out_pid == '0 && o_out_res.remaining == '0 && o_out_res.end_time == '0))
        else $error("idle result carries process data");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.dropped) |->
        (o_out_res.queue_count == rqs_pkg::QCNT_W'(rqs_pkg::QUEUE_DEPTH)))
        else $error("drop flagged with free slots");

    a_count_matches_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_stat.full) |-> (tbl_stat.count == rqs_pkg::CNT_W'(rqs_pkg::QUEUE_DEPTH)))
        else $error("table count out of step with valid bits");

endmodule

// File: rtl/rqs_table.sv
// ----------------------------------------------------------------------------
// rqs_table
// Ready table: slot memory with registered read, per-slot valid bits,
// occupancy count and lowest free slot.
// ----------------------------------------------------------------------------
module rqs_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rqs_pkg::t_tbl_req  i_req,
    input  rqs_pkg::t_slot     i_wr_data,
    output rqs_pkg::t_slot     o_rd_data,
    output logic               o_rd_vld,
    output rqs_pkg::t_tbl_stat o_stat
);

    rqs_pkg::t_slot                    r_mem [rqs_pkg::QUEUE_DEPTH];
    rqs_pkg::t_slot                    r_rd_data;
    logic                              r_rd_vld;
    logic [rqs_pkg::QUEUE_DEPTH-1:0]   r_valid;
    logic [rqs_pkg::QUEUE_DEPTH-1:0]   n_valid;
    logic [rqs_pkg::CNT_W-1:0]         r_count;
    logic [rqs_pkg::CNT_W-1:0]         n_count;
    logic [rqs_pkg::IDX_W-1:0]         free_idx;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_idx];
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (i_req.wr_en) begin
            n_valid[i_req.wr_idx] = 1'b1;
            n_count = r_count + 1'b1;
        end
        if (i_req.clr_en) begin
            n_valid[i_req.clr_idx] = 1'b0;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_rd_vld <= r_valid[i_req.rd_idx];
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = rqs_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = rqs_pkg::IDX_W'(i);
            end
        end
    end

    assign o_rd_data       = r_rd_data;
    assign o_rd_vld        = r_rd_vld;
    assign o_stat.full     = &r_valid;
    assign o_stat.free_idx = free_idx;
    assign o_stat.count    = r_count;

endmodule

// File: rtl/rqs_core.sv
// ----------------------------------------------------------------------------
// rqs_core
// Scheduling sequencer: running process registers, one shared key compare
// stepped over the table on completion, result register.
// ----------------------------------------------------------------------------
module rqs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_policy,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rqs_pkg::t_req      i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rqs_pkg::t_res      o_out_res,
    output rqs_pkg::t_tbl_req  o_tbl_req,
    output rqs_pkg::t_slot     o_wr_data,
    input  rqs_pkg::t_tbl_stat i_tbl_stat,
    input  rqs_pkg::t_slot     i_rd_data,
    input  logic               i_rd_vld
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ARRIVE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_CPL    = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    typedef struct packed {
        logic        vld;
        logic [15:0] pid;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  priority_lvl;
        logic [15:0] start;
        logic [16:0] end_t;
    } t_run;

    t_state                    r_state, n_state;
    rqs_pkg::t_req             r_item, n_item;
    t_run                      r_run, n_run;
    logic [rqs_pkg::IDX_W-1:0] r_cnt, n_cnt;
    logic                      r_cmp_en, n_cmp_en;
    logic [rqs_pkg::IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic                      r_best_found, n_best_found;
    logic [rqs_pkg::IDX_W-1:0] r_best_idx, n_best_idx;
    logic [15:0]               r_best_key, n_best_key;
    rqs_pkg::t_slot            r_best, n_best;
    rqs_pkg::t_res             r_pend, n_pend;
    logic                      r_out_valid, n_out_valid;
    rqs_pkg::t_res             r_out_res, n_out_res;

    logic                      in_xfer;
    logic                      null_proc;
    logic                      preempt;
    logic                      dropped;
    logic [15:0]               rem_out;
    logic [15:0]               cmp_key;
    logic                      better;
    logic [rqs_pkg::CNT_W-1:0] count_next;

    assign in_xfer   = i_in_valid && (r_state == S_IDLE);
    assign null_proc = (r_item.proc_id == '0) && (r_item.arrival_time == '0)
                    && (r_item.burst_time == '0) && (r_item.priority_req == '0);
    assign preempt   = (i_policy == rqs_pkg::POLICY_SRTF)
                     ? (r_item.burst_time <= r_item.running_remaining)
                     : (r_item.priority_req < r_run.priority_lvl);

    // shared compare unit
    assign cmp_key = (i_policy == rqs_pkg::POLICY_SRTF)
                   ? i_rd_data.remaining : {8'd0, i_rd_data.priority_lvl};
    assign better  = r_cmp_en && i_rd_vld && (!r_best_found || (cmp_key < r_best_key));

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_run        = r_run;
        n_cnt        = r_cnt;
        n_cmp_en     = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_best_found = r_best_found;
        n_best_idx   = r_best_idx;
        n_best_key   = r_best_key;
        n_best       = r_best;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_res    = r_out_res;
        dropped      = 1'b0;
        rem_out      = r_item.running_remaining;
        o_tbl_req    = '0;
        o_wr_data    = '0;

        if (better) begin
            n_best_found = 1'b1;
            n_best_idx   = r_cmp_idx;
            n_best_key   = cmp_key;
            n_best       = i_rd_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item       = i_in_req;
                    n_cnt        = '0;
                    n_best_found = 1'b0;
                    n_state      = (i_in_req.func == rqs_pkg::FUNC_COMPLETE)
                                 ? S_SCAN : S_ARRIVE;
                end
            end
            S_ARRIVE: begin
                if (!null_proc) begin
                    if (!r_run.vld || preempt) begin
                        if (r_run.vld) begin
                            o_tbl_req.wr_en        = !i_tbl_stat.full;
                            o_wr_data.pid          = r_run.pid;
                            o_wr_data.arrival      = r_run.arrival;
                            o_wr_data.burst        = r_run.burst;
                            o_wr_data.priority_lvl = r_run.priority_lvl;
                            o_wr_data.remaining    = (i_policy == rqs_pkg::POLICY_SRTF)
                                                   ? r_run.burst
                                                   : r_item.running_remaining;
                            dropped                = i_tbl_stat.full;
                        end
                        n_run.vld          = 1'b1;
                        n_run.pid          = r_item.proc_id;
                        n_run.arrival      = r_item.arrival_time;
                        n_run.burst        = r_item.burst_time;
                        n_run.priority_lvl = r_item.priority_req;
                        n_run.start        = r_item.timestamp;
                        n_run.end_t        = {1'b0, r_item.timestamp}
                                           + {1'b0, r_item.burst_time};
                        rem_out            = r_item.burst_time;
                    end else begin
                        o_tbl_req.wr_en        = !i_tbl_stat.full;
                        o_wr_data.pid          = r_item.proc_id;
                        o_wr_data.arrival      = r_item.arrival_time;
                        o_wr_data.burst        = r_item.burst_time;
                        o_wr_data.priority_lvl = r_item.priority_req;
                        o_wr_data.remaining    = r_item.burst_time;
                        dropped                = i_tbl_stat.full;
                    end
                end
                o_tbl_req.wr_idx = i_tbl_stat.free_idx;
                n_state          = S_FIN;
            end
            S_SCAN: begin
                o_tbl_req.rd_idx = r_cnt;
                n_cmp_en         = 1'b1;
                n_cmp_idx        = r_cnt;
                if (r_cnt == rqs_pkg::IDX_W'(rqs_pkg::QUEUE_DEPTH - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_CPL;
            end
            S_CPL: begin
                if (r_best_found) begin
                    o_tbl_req.clr_en   = 1'b1;
                    o_tbl_req.clr_idx  = r_best_idx;
                    n_run.vld          = 1'b1;
                    n_run.pid          = r_best.pid;
                    n_run.arrival      = r_best.arrival;
                    n_run.burst        = r_best.burst;
                    n_run.priority_lvl = r_best.priority_lvl;
                    n_run.start        = r_item.timestamp;
                    n_run.end_t        = {1'b0, r_item.timestamp} + {1'b0, r_best.remaining};
                    rem_out            = r_best.remaining;
                end else begin
                    n_run = '0;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        count_next = i_tbl_stat.count;
        if (o_tbl_req.wr_en) begin
            count_next = i_tbl_stat.count + 1'b1;
        end
        if (o_tbl_req.clr_en) begin
            count_next = i_tbl_stat.count - 1'b1;
        end

        if ((r_state == S_ARRIVE) || (r_state == S_CPL)) begin
            n_pend = '0;
            if (n_run.vld) begin
                n_pend.valid_res    = 1'b1;
                n_pend.out_pid      = n_run.pid;
                n_pend.out_arrival  = n_run.arrival;
                n_pend.out_burst    = n_run.burst;
                n_pend.out_priority = n_run.priority_lvl;
                n_pend.start_time   = n_run.start;
                n_pend.end_time     = n_run.end_t;
                n_pend.remaining    = rem_out;
            end
            n_pend.queue_count = rqs_pkg::QCNT_W'(count_next);
            n_pend.dropped     = dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run        <= '0;
            r_cmp_en     <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_cmp_en     <= n_cmp_en;
            r_best_found <= n_best_found;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_cnt      <= n_cnt;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_best     <= n_best;
        r_pend     <= n_pend;
        r_out_res  <= n_out_res;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
